/* rtl/cmx_pkg.sv */
// Package with the matrix geometry, the action codes and the pin-to-pixel LED table.
package cmx_pkg;

  localparam int MATRIX_WIDTH  = 14;
  localparam int MATRIX_HEIGHT = 9;
  localparam int PIN_COUNT     = 12;
  localparam int PIXELS        = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int PIX_W         = $clog2(PIXELS);
  localparam int ROW_W         = $clog2(PIN_COUNT);

  typedef logic [PIN_COUNT-1:0] pin_mask_t;
  typedef logic [PIX_W-1:0]     pix_idx_t;
  typedef logic [ROW_W-1:0]     row_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SCAN  = 2'd2
  } action_e;

  // Column pins that carry an LED while the given row pin sinks current.
  localparam pin_mask_t LED_EN [0:PIN_COUNT-1] = '{
    12'hFF8, 12'hFF8, 12'hFF8, 12'hFF7, 12'hFEF, 12'hFDF,
    12'hFBF, 12'hF7F, 12'hEFF, 12'hDFF, 12'hBFF, 12'h7FF
  };

  // Pixel lit by each row pin and column pin pair, where LED_EN marks one.
  localparam pix_idx_t LED_PIX [0:PIN_COUNT-1][0:PIN_COUNT-1] = '{
    '{  0,   0,   0, 124, 110,  96,  82,  68,  54,  40,  26,  12},
    '{  0,   0,   0, 122, 108,  94,  80,  66,  52,  38,  24,  10},
    '{  0,   0,   0, 120, 106,  92,  78,  64,  50,  36,  22,   8},
    '{125, 123, 121,   0,  98,  84,  70,  56,  42,  28,  14,   0},
    '{111, 109, 107, 112,   0,  85,  71,  57,  43,  29,  15,   1},
    '{ 97,  95,  93, 113,  99,   0,  72,  58,  44,  30,  16,   2},
    '{ 83,  81,  79, 114, 100,  86,   0,  59,  45,  31,  17,   3},
    '{ 69,  67,  65, 115, 101,  87,  73,   0,  46,  32,  18,   4},
    '{ 55,  53,  51, 116, 102,  88,  74,  60,   0,  33,  19,   5},
    '{ 41,  39,  37, 117, 103,  89,  75,  61,  47,   0,  20,   6},
    '{ 27,  25,  23, 118, 104,  90,  76,  62,  48,  34,   0,   7},
    '{ 13,  11,   9, 119, 105,  91,  77,  63,  49,  35,  21,   0}
  };

endpackage

/* rtl/charlieplex_matrix_scanner.sv */
// Top level of the charlieplexed LED matrix scanner with its framebuffer and pin drive logic.

// Each request is a pixel write, a pixel read or a scan tick; the block accepts one request
// per cycle and its response appears in the output register on the following cycle. The
// 14 by 9 framebuffer lives in flip-flops that reset clears at once, so the block is ready
// right after reset. A scan tick reads the row pin's pixels (nine or eleven) in parallel
// and updates the held pin masks, which then stay on drive_low_o and drive_high_o until the
// next tick. The only backpressure comes from a response that waits on a stalled output.
module charlieplex_matrix_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [3:0]                     x_i,
  input  logic [3:0]                     y_i,
  input  logic [7:0]                     pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic                           pixel_read_o,
  output logic [cmx_pkg::PIN_COUNT-1:0]  drive_low_o,
  output logic [cmx_pkg::PIN_COUNT-1:0]  drive_high_o,
  output logic [3:0]                     scan_row_o
);
  import cmx_pkg::*;

  logic [PIXELS-1:0] fb_q, fb_d;
  row_t              next_row_q, next_row_d;
  pin_mask_t         low_mask_q, low_mask_d;
  pin_mask_t         high_mask_q, high_mask_d;
  logic              out_valid_q, out_valid_d;
  logic              status_q, status_d;
  logic              pixel_read_q, pixel_read_d;
  row_t              scan_row_q, scan_row_d;
  logic              accept;
  logic              in_range;
  pix_idx_t          pix_idx;
  pin_mask_t         row_high;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (x_i < 4'(MATRIX_WIDTH)) && (y_i < 4'(MATRIX_HEIGHT));
  assign pix_idx    = PIX_W'(x_i) + PIX_W'(y_i) * PIX_W'(MATRIX_WIDTH);

  always_comb begin
    for (int c = 0; c < PIN_COUNT; c++) begin
      row_high[c] = LED_EN[next_row_q][c] && fb_q[LED_PIX[next_row_q][c]];
    end
  end

  always_comb begin
    fb_d         = fb_q;
    next_row_d   = next_row_q;
    low_mask_d   = low_mask_q;
    high_mask_d  = high_mask_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    pixel_read_d = pixel_read_q;
    scan_row_d   = scan_row_q;
    if (accept) begin
      out_valid_d  = 1'b1;
      status_d     = 1'b0;
      pixel_read_d = 1'b0;
      scan_row_d   = '0;
      unique case (action_e'(action_i))
        ACT_WRITE: begin
          if (in_range) begin
            fb_d[pix_idx] = |pixel_value_i;
          end else begin
            status_d = 1'b1;
          end
        end
        ACT_READ: begin
          if (in_range) begin
            pixel_read_d = fb_q[pix_idx];
          end else begin
            status_d = 1'b1;
          end
        end
        ACT_SCAN: begin
          low_mask_d  = pin_mask_t'(1) << next_row_q;
          high_mask_d = row_high;
          scan_row_d  = next_row_q;
          next_row_d  = (next_row_q == row_t'(PIN_COUNT - 1)) ? '0 : next_row_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q        <= '0;
      next_row_q  <= '0;
      low_mask_q  <= '0;
      high_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fb_q        <= fb_d;
      next_row_q  <= next_row_d;
      low_mask_q  <= low_mask_d;
      high_mask_q <= high_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    pixel_read_q <= pixel_read_d;
    scan_row_q   <= scan_row_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign pixel_read_o = pixel_read_q;
  assign drive_low_o  = low_mask_q;
  assign drive_high_o = high_mask_q;
  assign scan_row_o   = 4'(scan_row_q);

  a_stall_needs_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("Input stalled without a pending response.");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_row_q <= row_t'(PIN_COUNT - 1))
    else $error("Row counter left its range.");

  a_pins_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_mask_q & high_mask_q) == '0)
    else $error("A pin is driven both high and low.");

  a_scan_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ACT_SCAN) |=> $onehot(low_mask_q) && low_mask_q[scan_row_q])
    else $error("Scan tick did not select exactly its row pin.");

  a_bad_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_range && ((action_i == ACT_WRITE) || (action_i == ACT_READ))
    |=> status_q && !pixel_read_q)
    else $error("Out-of-range coordinate not reported.");

endmodule
